// File: src/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types and codes for the Fletcher block checksum core.
// ----------------------------------------------------------------------------
package fbc_pkg;

   localparam int WORD_W = 64;
   localparam int HALF_W = 32;
   localparam int KIND_W = 2;

   // Checksum kind codes; the unused code acts as off
   typedef enum logic [KIND_W-1:0] {
      KIND_OFF = 2'd0,
      KIND_F2  = 2'd1,
      KIND_F4  = 2'd2
   } kind_type;

   // Running checksum state of one block
   typedef struct packed {
      logic [WORD_W-1:0] acc_first;
      logic [WORD_W-1:0] acc_second;
      logic [WORD_W-1:0] acc_third;
      logic [WORD_W-1:0] acc_fourth;
      logic [WORD_W-1:0] held_word;
      logic              held_valid;
   } acc_type;

   // Counted parts of one input word
   typedef struct packed {
      logic use_low;
      logic use_high;
   } use_type;

endpackage

// File: src/fbc_update.sv
// ----------------------------------------------------------------------------
// fbc_update
// Folds one input word into the running Fletcher-2 or Fletcher-4 state.
// ----------------------------------------------------------------------------
module fbc_update (
   input  logic [1:0]        kind,
   input  logic [63:0]       data_word,
   input  fbc_pkg::use_type  use_flags,
   input  fbc_pkg::acc_type  acc_cur,
   output fbc_pkg::acc_type  acc_nxt
);
   import fbc_pkg::*;

   logic [WORD_W-1:0] low_half;
   logic [WORD_W-1:0] high_half;

   assign low_half  = {{(WORD_W-HALF_W){1'b0}}, data_word[HALF_W-1:0]};
   assign high_half = {{(WORD_W-HALF_W){1'b0}}, data_word[WORD_W-1:HALF_W]};

   // Accumulate by kind
   always_comb begin
      acc_type t;
      t = acc_cur;
      case (kind)
         KIND_F2: begin
            if (use_flags.use_low) begin
               if (t.held_valid) begin
                  t.acc_first  = t.acc_first + t.held_word;
                  t.acc_second = t.acc_second + data_word;
                  t.acc_third  = t.acc_third + t.acc_first;
                  t.acc_fourth = t.acc_fourth + t.acc_second;
                  t.held_valid = 1'b0;
                  t.held_word  = '0;
               end else begin
                  t.held_word  = data_word;
                  t.held_valid = 1'b1;
               end
            end
         end
         KIND_F4: begin
            if (use_flags.use_low) begin
               t.acc_first  = t.acc_first + low_half;
               t.acc_second = t.acc_second + t.acc_first;
               t.acc_third  = t.acc_third + t.acc_second;
               t.acc_fourth = t.acc_fourth + t.acc_third;
            end
            if (use_flags.use_high) begin
               t.acc_first  = t.acc_first + high_half;
               t.acc_second = t.acc_second + t.acc_first;
               t.acc_third  = t.acc_third + t.acc_second;
               t.acc_fourth = t.acc_fourth + t.acc_third;
            end
         end
         default: begin
            // off: data is ignored
         end
      endcase
      acc_nxt = t;
   end

endmodule

// File: src/fletcher_block_checksum_core.sv
// ----------------------------------------------------------------------------
// fletcher_block_checksum_core
// Fletcher-2 / Fletcher-4 checksum over a stream of 64-bit words.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tdata data_word, tuser flags, tlast
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata sum_word0..sum_word3
//  csr     | in  | csr_valid/csr_ready    | csr_data checksum_kind
//
// One word per cycle is accepted unless a full result slot holds back a last
// word; a word passes an input register and the accumulator adder chain, and a
// last word goes on to the result register. Reset clears the kind, the
// accumulators and all valid flags. A stalled result holds only a last word in
// the input register; other words keep flowing into the accumulators.
// ----------------------------------------------------------------------------
module fletcher_block_checksum_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,   // [63:0] data_word
   input  logic [1:0]    req_tuser,   // [0] use_low, [1] use_high
   input  logic          req_tlast,   // last
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [255:0]  rsp_tdata,   // [63:0] sum_word0, [127:64] sum_word1,
                                      // [191:128] sum_word2, [255:192] sum_word3
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_data     // checksum_kind
);
   import fbc_pkg::*;

   logic [KIND_W-1:0] kind_ff;
   logic              s1_valid_ff;
   logic [WORD_W-1:0] s1_word_ff;
   use_type           s1_use_ff;
   logic              s1_last_ff;
   logic              s1_advance;
   acc_type           acc_ff;
   acc_type           acc_in;
   logic              rsp_valid_ff;
   logic [4*WORD_W-1:0] rsp_data_ff;
   logic [4*WORD_W-1:0] rsp_data_in;
   logic              counts_kind;

   // Configuration: always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_OFF;
      end else if (csr_valid) begin
         kind_ff <= csr_data;
      end
   end

   // Advance the input register unless a last word meets a full result slot
   assign s1_advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         s1_word_ff         <= req_tdata;
         s1_use_ff.use_low  <= req_tuser[0];
         s1_use_ff.use_high <= req_tuser[1];
         s1_last_ff         <= req_tlast;
      end
   end

   fbc_update u_update (
      .kind      (kind_ff),
      .data_word (s1_word_ff),
      .use_flags (s1_use_ff),
      .acc_cur   (acc_ff),
      .acc_nxt   (acc_in)
   );

   // Hold accumulators; clear them after a last word
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (s1_advance) begin
         if (s1_last_ff) begin
            acc_ff <= '0;
         end else begin
            acc_ff <= acc_in;
         end
      end
   end

   // Build result words; off and the unused kind give zeros
   assign counts_kind = (kind_ff == KIND_F2) || (kind_ff == KIND_F4);
   assign rsp_data_in = counts_kind ?
                        {acc_in.acc_fourth, acc_in.acc_third,
                         acc_in.acc_second, acc_in.acc_first} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_last_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // A last word that leaves the input register shows up as a result
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_last_ff) |=> rsp_tvalid)
      else $error("last word did not produce a result");

   // State is clear after a block closes
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_last_ff) |=> (acc_ff == '0))
      else $error("accumulators not cleared after last word");

   // Off kinds report zero sums
   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_last_ff && !counts_kind) |=> (rsp_tdata == '0))
      else $error("off kind produced nonzero sums");

   // An empty input register never stalls the request side
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("request stalled with empty input register");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Fletcher block checksum core.
// Blocks of 64-bit words are streamed in under off, Fletcher-2, Fletcher-4
// and the unused kind, with random gaps and result back-pressure. A
// scoreboard keeps its own accumulators and compares every result, field
// by field, with the checksum it computed when the last word went in.
// ----------------------------------------------------------------------------
module tb;
   import fbc_pkg::*;

   localparam int    HALF_PERIOD  = 5;
   localparam int    RESET_CYCLES = 12;
   localparam int    RANDOM_ITEMS = 1825;
   localparam int    SETTLE_CYCLES = 8;
   localparam int    CYCLE_LIMIT  = 400000;
   localparam int    MAX_SHOWN    = 10;
   localparam int    MAX_GAP      = 12;
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;   // unused code, acts as off

   typedef logic [3:0][WORD_W-1:0] sums_type;

   // -------------------------------------------------------------------------
   // Scoreboard: running Fletcher sums and the queue of pending checksums
   // -------------------------------------------------------------------------
   class checksum_board;
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] sum0, sum1, sum2, sum3;
      logic [WORD_W-1:0] held_word;
      bit                held_valid;
      sums_type          pending_sums[$];
      int                errors;

      function new();
         kind   = KIND_OFF;
         errors = 0;
         clear_block();
      endfunction

      function void clear_block();
         sum0       = '0;
         sum1       = '0;
         sum2       = '0;
         sum3       = '0;
         held_word  = '0;
         held_valid = 1'b0;
      endfunction

      function void set_kind(logic [KIND_W-1:0] k);
         kind = k;
      endfunction

      // Push one 32-bit half down the a, b, c, d chain
      function void fold_half(logic [HALF_W-1:0] half);
         sum0 += {{(WORD_W-HALF_W){1'b0}}, half};
         sum1 += sum0;
         sum2 += sum1;
         sum3 += sum2;
      endfunction

      // Apply one accepted word; queue a checksum on last
      function void note_word(logic [WORD_W-1:0] w, logic lo, logic hi, logic fin);
         sums_type s;
         if (kind == KIND_F2) begin
            if (lo) begin
               if (held_valid) begin
                  sum0 += held_word;
                  sum1 += w;
                  sum2 += sum0;
                  sum3 += sum1;
                  held_word  = '0;
                  held_valid = 1'b0;
               end else begin
                  held_word  = w;
                  held_valid = 1'b1;
               end
            end
         end else if (kind == KIND_F4) begin
            if (lo) fold_half(w[HALF_W-1:0]);
            if (hi) fold_half(w[WORD_W-1:HALF_W]);
         end
         if (fin) begin
            if (kind == KIND_F2 || kind == KIND_F4) s = {sum3, sum2, sum1, sum0};
            else s = '0;
            pending_sums.push_back(s);
            clear_block();
         end
      endfunction

      function int pending();
         return pending_sums.size();
      endfunction

      // Compare one result transfer with the oldest pending checksum
      function void check_sums(sums_type got);
         sums_type want;
         if (pending_sums.size() == 0) begin
            errors++;
            if (errors <= MAX_SHOWN) $display("unexpected checksum result %h", got);
            return;
         end
         want = pending_sums.pop_front();
         for (int i = 0; i < 4; i++) begin
            if (got[i] !== want[i]) begin
               errors++;
               if (errors <= MAX_SHOWN)
                  $display("sum_word%0d mismatch: expected %h actual %h", i, want[i], got[i]);
            end
         end
      endfunction

      // Count checksums that never came out
      function void close_out();
         if (pending_sums.size() != 0) begin
            errors += pending_sums.size();
            $display("%0d checksum results missing", pending_sums.size());
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and block
   // -------------------------------------------------------------------------
   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [WORD_W-1:0]  req_tdata  = '0;   // [63:0] data_word
   logic [1:0]         req_tuser  = '0;   // [0] use_low, [1] use_high
   logic               req_tlast  = 1'b0; // last
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [255:0]       rsp_tdata;         // sum_word0, sum_word1, sum_word2, sum_word3
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [KIND_W-1:0]  csr_data   = '0;   // checksum_kind

   checksum_board board = new();

   bit req_idle_on  = 1'b0;
   bit rsp_stall_on = 1'b0;
   int hold_req     = 0;
   int cycle_count  = 0;

   fletcher_block_checksum_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Feed every accepted word to the scoreboard
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_word(req_tdata, req_tuser[0], req_tuser[1], req_tlast);
   end

   // Result side: random stalls, long hold-offs on request, checking
   initial begin : rsp_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            board.check_sums(rsp_tdata);
            stall_left = rsp_stall_on ? $urandom_range(0, MAX_GAP) : 0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Drive tasks
   // -------------------------------------------------------------------------
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return '1;
         1:       return '0;
         2:       return {32'hFFFF_FFFF, 32'h0000_0000};
         3:       return {32'h0000_0000, 32'hFFFF_FFFF};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offer one word after a random gap; return at its transfer
   task automatic send_word(input logic [WORD_W-1:0] w, input logic lo, input logic hi,
                            input logic fin);
      int gap;
      gap = req_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= {hi, lo};
      req_tlast  <= fin;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
   endtask

   // Drop valid, wait for every pending checksum, then let the pipe drain
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_kind(input logic [KIND_W-1:0] k);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= k;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      board.set_kind(k);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : main
      int                counted;
      int                phase;
      int                nblocks;
      int                len;
      logic [KIND_W-1:0] k;
      bit                open_end;
      bit                fin;
      logic              lo, hi;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: off after reset gives zeros
      rsp_stall_on = 1'b1;
      send_word('1, 1'b1, 1'b1, 1'b1);

      // Fletcher-2 extremes; the fifth word stays unpaired and is dropped
      settle();
      write_kind(KIND_F2);
      send_word('1, 1'b1, 1'b0, 1'b0);
      send_word('1, 1'b1, 1'b1, 1'b0);
      send_word('0, 1'b1, 1'b0, 1'b0);
      send_word(64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0);
      send_word({$urandom, $urandom}, 1'b1, 1'b0, 1'b1);
      // Uncounted word still closes the block
      send_word('1, 1'b0, 1'b0, 1'b1);
      // High flag alone is ignored, lone held word dropped at last
      send_word('1, 1'b0, 1'b1, 1'b0);
      send_word({$urandom, $urandom}, 1'b1, 1'b0, 1'b1);

      // Fletcher-4: both halves, high half alone, low half alone
      settle();
      write_kind(KIND_F4);
      send_word('1, 1'b1, 1'b1, 1'b0);
      send_word({32'hFFFF_FFFF, 32'h1234_5678}, 1'b0, 1'b1, 1'b0);
      send_word({32'h8765_4321, 32'hFFFF_FFFF}, 1'b1, 1'b0, 1'b0);
      send_word({$urandom, $urandom}, 1'b1, 1'b1, 1'b1);
      send_word('0, 1'b1, 1'b1, 1'b1);

      // Kind change inside a block: state carries across the switch
      send_word({$urandom, $urandom}, 1'b1, 1'b1, 1'b0);
      settle();
      write_kind(KIND_F2);
      send_word({$urandom, $urandom}, 1'b1, 1'b0, 1'b0);
      settle();
      write_kind(KIND_F4);
      send_word({$urandom, $urandom}, 1'b1, 1'b1, 1'b0);
      settle();
      write_kind(KIND_F2);
      send_word({$urandom, $urandom}, 1'b1, 1'b0, 1'b1);

      // Unused kind acts as off
      settle();
      write_kind(KIND_SPARE);
      send_word('1, 1'b1, 1'b1, 1'b0);
      send_word({$urandom, $urandom}, 1'b1, 1'b1, 1'b1);
      settle();
      write_kind(KIND_OFF);
      send_word({$urandom, $urandom}, 1'b1, 1'b1, 1'b1);

      // Random phases, each under one kind with its own idle pattern
      counted = 0;
      phase   = 0;
      while (counted < RANDOM_ITEMS) begin
         case (phase)
            0: k = KIND_F2;
            1: k = KIND_F4;
            2: k = KIND_OFF;
            3: k = KIND_SPARE;
            default: begin
               case ($urandom_range(0, 9))
                  0:       k = KIND_OFF;
                  1:       k = KIND_SPARE;
                  2, 3, 4, 5: k = KIND_F2;
                  default: k = KIND_F4;
               endcase
            end
         endcase
         settle();
         write_kind(k);
         req_idle_on  = ($urandom_range(0, 2) != 0);
         rsp_stall_on = ($urandom_range(0, 2) != 0);
         // Back-pressure phase: results blocked while words are still offered
         if (phase % 7 == 2) begin
            req_idle_on  = 1'b0;
            rsp_stall_on = 1'b0;
            hold_req     = $urandom_range(150, 300);
         end
         nblocks = (k == KIND_F2 || k == KIND_F4) ? $urandom_range(4, 12)
                                                  : $urandom_range(2, 4);
         for (int b = 0; b < nblocks; b++) begin
            open_end = (b == nblocks - 1) && ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
               fin = (i == len - 1) && !open_end;
               if ($urandom_range(0, 5) == 0) begin
                  // noise: any flag combination
                  {hi, lo} = 2'($urandom_range(0, 3));
               end else if (k == KIND_F4) begin
                  lo = ($urandom_range(0, 7) != 0);
                  hi = ($urandom_range(0, 7) != 0);
               end else begin
                  lo = 1'b1;
                  hi = 1'($urandom_range(0, 1));
               end
               send_word(pick_word(), lo, hi, fin);
               counted++;
            end
         end
         phase++;
      end

      // Drain and report
      settle();
      board.close_out();
      if (board.errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
